// ===== hdl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Types and constants shared by the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int ITEM_W    = 64;
	localparam int ENTRIES_W = 5;

	typedef enum logic [2:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_PEEK_FRONT = 3'd4,
		ACT_PEEK_BACK  = 3'd5,
		ACT_CLEAR      = 3'd6,
		ACT_EXIT       = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_EMPTY = 3'd1,
		ST_DATA  = 3'd2,
		ST_BYE   = 3'd3,
		ST_FULL  = 3'd4
	} status_t;

	typedef struct packed {
		action_t             action;
		logic [ITEM_W-1:0]   item_value;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [ITEM_W-1:0]    item_out;
		logic [ENTRIES_W-1:0] entries_held;
	} rsp_t;

endpackage

// ===== hdl/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Simple dual-port item store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module deq_ram #(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4,
	parameter int DATA_W = 64
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/double_ended_queue_top.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue held as a ring in a synchronous item store.
// ----------------------------------------------------------------------------
// A request (req) is taken on a rising edge with start high and busy low.
// Pushes write the store in that cycle; pops and peeks issue a store read
// whose data comes back in the following cycle. Front pointer and count live in
// registers and update in the request cycle.
// Every transaction yields one result on rsp, marked by done for exactly one
// cycle, on the cycle after the request was taken.
// A request may be presented every cycle; the registered store read is the
// only stage and a write is visible to a read in the following cycle, so
// the sustained rate is one transaction per cycle.
// Reset clears the pointer and count, empties the queue and holds busy high
// for the first cycle after reset is released. Store contents are not
// cleared; only occupied slots are ever read.
// The receiver cannot stall: each result must be taken while done is high.
// ----------------------------------------------------------------------------
module double_ended_queue_top
	import deq_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = CNT_W + 1;

	logic              busy_q;
	logic [PTR_W-1:0]  front_q;
	logic [CNT_W-1:0]  count_q;
	logic              done_q;
	logic              rd_q;
	status_t           status_q;

	logic              take;
	logic              full;
	logic              empty;
	logic [PTR_W-1:0]  front_dec;
	logic [PTR_W-1:0]  front_inc;
	logic [SUM_W-1:0]  back_sum;
	logic [SUM_W-1:0]  tail_sum;
	logic [PTR_W-1:0]  back_slot;
	logic [PTR_W-1:0]  tail_slot;

	logic              wr_en;
	logic [PTR_W-1:0]  wr_addr;
	logic              rd_en;
	logic [PTR_W-1:0]  rd_addr;
	logic [PTR_W-1:0]  front_d;
	logic [CNT_W-1:0]  count_d;
	status_t           status_d;
	logic [ITEM_W-1:0] rd_data;

	assign take  = start & ~busy_q;
	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);

	assign front_dec = (front_q == '0) ? PTR_W'(CAPACITY - 1) : front_q - 1'b1;
	assign front_inc = (front_q == PTR_W'(CAPACITY - 1)) ? '0 : front_q + 1'b1;

	// slot after the back item, and the back item itself
	always_comb begin
		back_sum = SUM_W'(front_q) + SUM_W'(count_q);
		if (back_sum >= SUM_W'(CAPACITY)) begin
			back_sum = back_sum - SUM_W'(CAPACITY);
		end
		tail_sum = SUM_W'(front_q) + SUM_W'(count_q) - 1'b1;
		if (tail_sum >= SUM_W'(CAPACITY)) begin
			tail_sum = tail_sum - SUM_W'(CAPACITY);
		end
		back_slot = back_sum[PTR_W-1:0];
		tail_slot = tail_sum[PTR_W-1:0];
	end

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = front_dec;
		rd_en    = 1'b0;
		rd_addr  = front_q;
		front_d  = front_q;
		count_d  = count_q;
		status_d = ST_OK;
		unique case (req.action) inside
			ACT_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = front_dec;
					front_d = front_dec;
					count_d = count_q + 1'b1;
				end
			end
			ACT_PUSH_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = back_slot;
					count_d = count_q + 1'b1;
				end
			end
			ACT_POP_FRONT, ACT_PEEK_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					status_d = ST_DATA;
					rd_en    = 1'b1;
					rd_addr  = front_q;
					if (req.action == ACT_POP_FRONT) begin
						front_d = front_inc;
						count_d = count_q - 1'b1;
					end
				end
			end
			ACT_POP_BACK, ACT_PEEK_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					status_d = ST_DATA;
					rd_en    = 1'b1;
					rd_addr  = tail_slot;
					if (req.action == ACT_POP_BACK) begin
						count_d = count_q - 1'b1;
					end
				end
			end
			ACT_CLEAR: begin
				front_d = '0;
				count_d = '0;
			end
			default: begin
				status_d = ST_BYE;
			end
		endcase
	end

	deq_ram #(
		.DEPTH  (CAPACITY),
		.ADDR_W (PTR_W),
		.DATA_W (ITEM_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (take & wr_en),
		.wr_addr (wr_addr),
		.wr_data (req.item_value),
		.rd_en   (take & rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			front_q <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			busy_q <= 1'b0;
			done_q <= take;
			rd_q   <= take & rd_en;
			if (take) begin
				front_q <= front_d;
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q <= status_d;
		end
	end

	assign busy             = busy_q;
	assign done             = done_q;
	assign rsp.status       = status_q;
	assign rsp.item_out     = rd_q ? rd_data : '0;
	assign rsp.entries_held = ENTRIES_W'(count_q);

endmodule

// ===== tb/tb_double_ended_queue_top.sv =====
// ----------------------------------------------------------------------------
// tb_double_ended_queue_top
// Self-checking testbench for the bounded double-ended queue.
// ----------------------------------------------------------------------------
// A short table of directed transactions comes first. It covers empty pops and
// peeks, exit, pushes of zero and all-ones words, and filling the ring until
// a push is refused. It also covers draining and clearing. Every row is run
// through the queue predictor. Rows that carry a typed-in result are checked
// against that result, and the other rows against the prediction.
// Random transactions follow in three phases with different request gaps.
// The random mix swings between fill-heavy and drain-heavy stretches, so the
// count keeps reaching both full and empty. Each result strobe is compared
// field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_top;
	import deq_pkg::*;

	localparam int CAPACITY     = 16;
	localparam int DIR_ROWS     = 25;
	localparam int LIMIT_CYCLES = 40000;

	typedef struct {
		action_t     act;
		logic [63:0] value;
		int          reps;
		bit          typed;
		rsp_t        want;
	} stim_row_t;

	typedef struct {
		bit   typed;
		rsp_t want;
	} typed_rsp_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	double_ended_queue_top #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	// predictor state
	logic [63:0] ring [CAPACITY];
	int unsigned head;
	int unsigned held;

	rsp_t       expected_rsp_q [$];
	typed_rsp_t typed_rsp_q [$];
	stim_row_t  dir_tab [DIR_ROWS];

	int unsigned idle_pct;
	int unsigned cycles;
	int unsigned n_taken, n_checked, n_errors;
	int unsigned n_full, n_empty, n_data, n_clear;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic rsp_t rsp_of(status_t s, logic [63:0] d, logic [4:0] n);
		rsp_t o;
		o.status       = s;
		o.item_out     = d;
		o.entries_held = n;
		return o;
	endfunction

	function automatic stim_row_t row(action_t a, logic [63:0] v, int reps, bit typed,
		rsp_t want);
		stim_row_t r;
		r.act   = a;
		r.value = v;
		r.reps  = reps;
		r.typed = typed;
		r.want  = want;
		return r;
	endfunction

	function automatic rsp_t deque_step(req_t r);
		rsp_t o;
		o.status   = ST_OK;
		o.item_out = '0;
		case (r.action)
			ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
				if (held >= CAPACITY) begin
					o.status = ST_FULL;
				end else if (r.action == ACT_PUSH_FRONT) begin
					head       = (head == 0) ? CAPACITY - 1 : head - 1;
					ring[head] = r.item_value;
					held++;
				end else begin
					ring[(head + held) % CAPACITY] = r.item_value;
					held++;
				end
			end
			ACT_POP_FRONT, ACT_PEEK_FRONT: begin
				if (held == 0) begin
					o.status = ST_EMPTY;
				end else begin
					o.status   = ST_DATA;
					o.item_out = ring[head];
					if (r.action == ACT_POP_FRONT) begin
						head = (head + 1) % CAPACITY;
						held--;
					end
				end
			end
			ACT_POP_BACK, ACT_PEEK_BACK: begin
				if (held == 0) begin
					o.status = ST_EMPTY;
				end else begin
					o.status   = ST_DATA;
					o.item_out = ring[(head + held - 1) % CAPACITY];
					if (r.action == ACT_POP_BACK)
						held--;
				end
			end
			ACT_CLEAR: begin
				held = 0;
				head = 0;
			end
			default: o.status = ST_BYE;
		endcase
		o.entries_held = held[4:0];
		return o;
	endfunction

	// results are taken and requests accepted on the same edge; both sampled pre-edge
	always @(posedge clk) begin
		rsp_t       want;
		rsp_t       pred;
		typed_rsp_t sel;
		if (arst_n) begin
			if (done) begin
				if (expected_rsp_q.size() == 0) begin
					$error("result with no transaction waiting: status %0d item %h held %0d",
						rsp.status, rsp.item_out, rsp.entries_held);
					n_errors++;
				end else begin
					want = expected_rsp_q.pop_front();
					n_checked++;
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						n_errors++;
					end
					if (rsp.item_out !== want.item_out) begin
						$error("item_out: expected %h, got %h", want.item_out, rsp.item_out);
						n_errors++;
					end
					if (rsp.entries_held !== want.entries_held) begin
						$error("entries_held: expected %0d, got %0d", want.entries_held,
							rsp.entries_held);
						n_errors++;
					end
				end
			end
			if (start && !busy) begin
				pred = deque_step(req);
				sel  = typed_rsp_q.pop_front();
				expected_rsp_q.push_back(sel.typed ? sel.want : pred);
				n_taken++;
				case (pred.status)
					ST_FULL:  n_full++;
					ST_EMPTY: n_empty++;
					ST_DATA:  n_data++;
					default:  ;
				endcase
				if (req.action == ACT_CLEAR)
					n_clear++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				expected_rsp_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic issue(req_t r, bit typed, rsp_t want);
		typed_rsp_t sel;
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		sel.typed = typed;
		sel.want  = want;
		typed_rsp_q.push_back(sel);
		req   <= r;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic run_random(int unsigned count, int unsigned gap_pct);
		req_t        r;
		int unsigned roll;
		bit          fill_bias;
		fill_bias = 1'b1;
		idle_pct  = gap_pct;
		for (int unsigned i = 0; i < count; i++) begin
			if ($urandom_range(0, 29) == 0)
				fill_bias = !fill_bias;
			roll = $urandom_range(0, 99);
			if (roll < 3)
				r.action = ACT_CLEAR;
			else if (roll < 6)
				r.action = ACT_EXIT;
			else if (roll < (fill_bias ? 70 : 28))
				r.action = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
			else
				case ($urandom_range(0, 3))
					0:       r.action = ACT_POP_FRONT;
					1:       r.action = ACT_POP_BACK;
					2:       r.action = ACT_PEEK_FRONT;
					default: r.action = ACT_PEEK_BACK;
				endcase
			case ($urandom_range(0, 9))
				0:       r.item_value = '0;
				1:       r.item_value = '1;
				default: r.item_value = {$urandom, $urandom};
			endcase
			issue(r, 1'b0, '0);
		end
	endtask

	initial begin
		req_t r;
		arst_n   = 1'b0;
		start    = 1'b0;
		req      = '0;
		idle_pct = 0;
		cycles   = 0;
		n_taken  = 0;
		n_checked = 0;
		n_errors = 0;
		n_full   = 0;
		n_empty  = 0;
		n_data   = 0;
		n_clear  = 0;
		head     = 0;
		held     = 0;

		dir_tab[0]  = row(ACT_POP_FRONT, 64'd0, 1, 1, rsp_of(ST_EMPTY, 64'd0, 5'd0));
		dir_tab[1]  = row(ACT_POP_BACK, 64'd0, 1, 1, rsp_of(ST_EMPTY, 64'd0, 5'd0));
		dir_tab[2]  = row(ACT_PEEK_FRONT, 64'd0, 1, 1, rsp_of(ST_EMPTY, 64'd0, 5'd0));
		dir_tab[3]  = row(ACT_PEEK_BACK, 64'd0, 1, 1, rsp_of(ST_EMPTY, 64'd0, 5'd0));
		dir_tab[4]  = row(ACT_EXIT, '1, 1, 1, rsp_of(ST_BYE, 64'd0, 5'd0));
		dir_tab[5]  = row(ACT_PUSH_FRONT, '1, 1, 1, rsp_of(ST_OK, 64'd0, 5'd1));
		dir_tab[6]  = row(ACT_PUSH_BACK, 64'd0, 1, 1, rsp_of(ST_OK, 64'd0, 5'd2));
		dir_tab[7]  = row(ACT_PEEK_FRONT, 64'd0, 1, 1, rsp_of(ST_DATA, '1, 5'd2));
		dir_tab[8]  = row(ACT_PEEK_BACK, 64'd0, 1, 1, rsp_of(ST_DATA, 64'd0, 5'd2));
		dir_tab[9]  = row(ACT_POP_FRONT, 64'd0, 1, 1, rsp_of(ST_DATA, '1, 5'd1));
		dir_tab[10] = row(ACT_POP_BACK, 64'd0, 1, 1, rsp_of(ST_DATA, 64'd0, 5'd0));
		dir_tab[11] = row(ACT_POP_BACK, 64'd0, 1, 1, rsp_of(ST_EMPTY, 64'd0, 5'd0));
		// front pushes wrap the pointer below slot zero
		dir_tab[12] = row(ACT_PUSH_FRONT, 64'h0123_4567_89ab_cdef, 9, 0, '0);
		dir_tab[13] = row(ACT_PUSH_BACK, 64'hfedc_ba98_7654_3210, 7, 0, '0);
		dir_tab[14] = row(ACT_PUSH_FRONT, 64'h5555_5555_5555_5555, 1, 1,
			rsp_of(ST_FULL, 64'd0, 5'd16));
		dir_tab[15] = row(ACT_PUSH_BACK, 64'haaaa_aaaa_aaaa_aaaa, 1, 1,
			rsp_of(ST_FULL, 64'd0, 5'd16));
		dir_tab[16] = row(ACT_EXIT, 64'd0, 1, 1, rsp_of(ST_BYE, 64'd0, 5'd16));
		dir_tab[17] = row(ACT_PEEK_FRONT, 64'd0, 1, 0, '0);
		dir_tab[18] = row(ACT_PEEK_BACK, 64'd0, 1, 0, '0);
		dir_tab[19] = row(ACT_POP_FRONT, 64'd0, 2, 0, '0);
		dir_tab[20] = row(ACT_POP_BACK, 64'd0, 2, 0, '0);
		dir_tab[21] = row(ACT_CLEAR, 64'd0, 1, 1, rsp_of(ST_OK, 64'd0, 5'd0));
		dir_tab[22] = row(ACT_PEEK_FRONT, 64'd0, 1, 1, rsp_of(ST_EMPTY, 64'd0, 5'd0));
		dir_tab[23] = row(ACT_PUSH_BACK, 64'h8000_0000_0000_0001, 1, 1,
			rsp_of(ST_OK, 64'd0, 5'd1));
		dir_tab[24] = row(ACT_POP_FRONT, 64'd0, 1, 1,
			rsp_of(ST_DATA, 64'h8000_0000_0000_0001, 5'd0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		idle_pct = 21;
		foreach (dir_tab[i]) begin
			for (int k = 0; k < dir_tab[i].reps; k++) begin
				r.action     = dir_tab[i].act;
				r.item_value = dir_tab[i].value + 64'(k);
				issue(r, dir_tab[i].typed, dir_tab[i].want);
			end
		end

		run_random(184, 21);
		run_random(184, 52);
		run_random(182, 0);
		start <= 1'b0;

		while (expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("%0d transactions, %0d results checked, %0d mismatches", n_taken,
			n_checked, n_errors);
		$display("data returned %0d, empty errors %0d, full refusals %0d, clears %0d",
			n_data, n_empty, n_full, n_clear);
		if (n_errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
